FILE: sv/neighbor_table_ttl_aging_assert.svh
// Assertion helpers for the neighbor table.
`ifndef NEIGHBOR_TABLE_TTL_AGING_ASSERT_SVH
`define NEIGHBOR_TABLE_TTL_AGING_ASSERT_SVH

// Check a property on every clock edge outside reset.
`define NTA_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Check a property on every clock edge, reset included.
`define NTA_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

FILE: sv/nta_pkg.sv
`default_nettype none
package nta_pkg;
	localparam int DEPTH_DEF  = 16;
	localparam int OP_W       = 3;
	localparam int ADDR_W     = 8;
	localparam int TTL_W      = 8;
	localparam int USE_W      = 5;

	localparam logic [TTL_W-1:0] TTL_RESET = 8'd30;

	localparam logic [OP_W-1:0] OP_ADD     = 3'd0;
	localparam logic [OP_W-1:0] OP_REFRESH = 3'd1;
	localparam logic [OP_W-1:0] OP_TICK    = 3'd2;
	localparam logic [OP_W-1:0] OP_PURGE   = 3'd3;
	localparam logic [OP_W-1:0] OP_QUERY   = 3'd4;
	localparam logic [OP_W-1:0] OP_CLEAR   = 3'd5;

	typedef logic [ADDR_W-1:0] addr_t;
	typedef logic [TTL_W-1:0]  ttl_t;
endpackage
`default_nettype wire

FILE: sv/neighbor_table_ttl_aging.sv
// Neighbor table with TTL aging: TABLE_DEPTH entries, each an 8-bit peer address and an
// 8-bit time-to-live. A request is one of add, refresh, tick, purge, query or clear and
// yields exactly one result with found, remaining_ttl, rejected_full and entries_in_use.
// Address and TTL live in one single-port-read memory that a sequencer sweeps one entry
// per cycle; valid marks sit in flip-flops and are cleared at reset. Add, refresh, tick,
// purge and query sweep the whole table between acceptance and the next acceptance
// (TABLE_DEPTH reads, a drain state for the registered read, a done state to write back
// and post the result, an idle state to take the next request); clear and unknown codes
// go straight to the done state. The memory read port paces the sweep. The result sits
// in an output register, so the next request is taken while the previous result still
// waits; a second result that finds the register still full holds the sequencer until
// it drains. ttl_reload may be written only while the block is idle. entries_in_use is
// the valid count kept modulo 32.
`default_nettype none
`include "neighbor_table_ttl_aging_assert.svh"
module neighbor_table_ttl_aging #(
	parameter int TABLE_DEPTH = nta_pkg::DEPTH_DEF
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      cfg_we,
	input  wire logic [nta_pkg::TTL_W-1:0] cfg_wdata,
	input  wire logic                      in_valid,
	output logic                           in_ready,
	input  wire logic [nta_pkg::OP_W-1:0]  operation,
	input  wire logic [nta_pkg::ADDR_W-1:0] peer_address,
	output logic                           out_valid,
	input  wire logic                      out_ready,
	output logic                           found,
	output logic [nta_pkg::TTL_W-1:0]      remaining_ttl,
	output logic                           rejected_full,
	output logic [nta_pkg::USE_W-1:0]      entries_in_use
);
	localparam int IDX_W  = $clog2(TABLE_DEPTH);
	localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);
	localparam int WORD_W = nta_pkg::ADDR_W + nta_pkg::TTL_W;
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_DEPTH - 1);

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_SCAN  = 2'd1;
	localparam logic [1:0] ST_DRAIN = 2'd2;
	localparam logic [1:0] ST_DONE  = 2'd3;

	logic [1:0]             state_q;
	nta_pkg::ttl_t          ttl_reload_q;
	logic [TABLE_DEPTH-1:0] valid_q;
	logic [CNT_W-1:0]       cnt_q;

	// request held for the whole sweep
	logic [nta_pkg::OP_W-1:0] op_q;
	nta_pkg::addr_t           addr_q;

	// sweep results
	logic          match_hit_q;
	logic [IDX_W-1:0] match_idx_q;
	nta_pkg::ttl_t match_ttl_q;
	logic          free_hit_q;
	logic [IDX_W-1:0] free_idx_q;

	// read address, then one registered read stage
	logic [IDX_W-1:0]  rd_idx_q;
	logic              chk_vld_s1;
	logic [IDX_W-1:0]  chk_idx_s1;
	logic [WORD_W-1:0] rd_word_s1;

	logic [WORD_W-1:0] mem [TABLE_DEPTH];

	// result register
	logic          out_valid_q;
	logic          found_q;
	nta_pkg::ttl_t ttl_q;
	logic          full_q;
	logic [nta_pkg::USE_W-1:0] use_q;

	logic              in_fire;
	logic              done_fire;
	logic              scan_op;
	nta_pkg::addr_t    chk_addr;
	nta_pkg::ttl_t     chk_ttl;
	logic              chk_v;
	logic              tick_wr;
	logic              purge_hit;
	logic              add_new;
	logic              mem_we;
	logic [IDX_W-1:0]  mem_wa;
	logic [WORD_W-1:0] mem_wd;
	logic              res_found;
	nta_pkg::ttl_t     res_ttl;
	logic              res_full;
	logic [CNT_W-1:0]  cnt_done;

	assign in_ready  = (state_q == ST_IDLE);
	assign in_fire   = in_valid && in_ready;
	assign done_fire = (state_q == ST_DONE) && (!out_valid_q || out_ready);

	// clear and unknown codes need no sweep
	assign scan_op = (operation == nta_pkg::OP_ADD) || (operation == nta_pkg::OP_REFRESH) ||
		(operation == nta_pkg::OP_TICK) || (operation == nta_pkg::OP_PURGE) ||
		(operation == nta_pkg::OP_QUERY);

	assign chk_addr  = rd_word_s1[nta_pkg::TTL_W +: nta_pkg::ADDR_W];
	assign chk_ttl   = rd_word_s1[nta_pkg::TTL_W-1:0];
	assign chk_v     = valid_q[chk_idx_s1];
	assign tick_wr   = chk_vld_s1 && (op_q == nta_pkg::OP_TICK) && chk_v && (chk_ttl != '0);
	assign purge_hit = chk_vld_s1 && (op_q == nta_pkg::OP_PURGE) && chk_v && (chk_ttl == '0);
	assign add_new   = (op_q == nta_pkg::OP_ADD) && !match_hit_q && free_hit_q;

	// Result of the finished sweep.
	always_comb begin
		res_found = 1'b0;
		res_ttl   = '0;
		res_full  = 1'b0;
		cnt_done  = cnt_q;
		unique case (op_q)
			nta_pkg::OP_ADD: begin
				res_found = match_hit_q;
				if (match_hit_q) begin
					res_ttl = match_ttl_q;
				end else if (free_hit_q) begin
					res_ttl  = ttl_reload_q;
					cnt_done = cnt_q + CNT_W'(1);
				end else begin
					res_full = 1'b1;
				end
			end
			nta_pkg::OP_REFRESH: begin
				res_found = match_hit_q;
				res_ttl   = match_hit_q ? ttl_reload_q : '0;
			end
			nta_pkg::OP_QUERY: begin
				res_found = match_hit_q;
				res_ttl   = match_hit_q ? match_ttl_q : '0;
			end
			nta_pkg::OP_CLEAR: begin
				cnt_done = '0;
			end
			default: begin
			end
		endcase
	end

	// One write port: tick decrements during the sweep, add and refresh write at the end.
	always_comb begin
		mem_we = 1'b0;
		mem_wa = chk_idx_s1;
		mem_wd = {chk_addr, chk_ttl - nta_pkg::TTL_W'(1)};
		if (tick_wr) begin
			mem_we = 1'b1;
		end else if (done_fire && add_new) begin
			mem_we = 1'b1;
			mem_wa = free_idx_q;
			mem_wd = {addr_q, ttl_reload_q};
		end else if (done_fire && (op_q == nta_pkg::OP_REFRESH) && match_hit_q) begin
			mem_we = 1'b1;
			mem_wa = match_idx_q;
			mem_wd = {addr_q, ttl_reload_q};
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_wa] <= mem_wd;
		end
		rd_word_s1 <= mem[rd_idx_q];
	end

	// Request and sweep bookkeeping (payload, no reset).
	always_ff @(posedge clk) begin
		chk_idx_s1 <= rd_idx_q;
		if (in_fire) begin
			op_q   <= operation;
			addr_q <= peer_address;
		end
		if (done_fire) begin
			found_q <= res_found;
			ttl_q   <= res_ttl;
			full_q  <= res_full;
			use_q   <= nta_pkg::USE_W'(cnt_done);
		end
		if (chk_vld_s1 && !match_hit_q && chk_v && (chk_addr == addr_q)) begin
			match_idx_q <= chk_idx_s1;
			match_ttl_q <= chk_ttl;
		end
		if (chk_vld_s1 && !free_hit_q && !chk_v) begin
			free_idx_q <= chk_idx_s1;
		end
	end

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			ttl_reload_q <= nta_pkg::TTL_RESET;
			valid_q      <= '0;
			cnt_q        <= '0;
			rd_idx_q     <= '0;
			chk_vld_s1   <= 1'b0;
			match_hit_q  <= 1'b0;
			free_hit_q   <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cfg_we) begin
				ttl_reload_q <= cfg_wdata;
			end
			chk_vld_s1 <= (state_q == ST_SCAN);
			// post a new result, else drop the one just taken
			if (done_fire) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			// capture first match and first free slot as the sweep passes
			if (chk_vld_s1 && !match_hit_q && chk_v && (chk_addr == addr_q)) begin
				match_hit_q <= 1'b1;
			end
			if (chk_vld_s1 && !free_hit_q && !chk_v) begin
				free_hit_q <= 1'b1;
			end
			// drop expired entries
			if (purge_hit) begin
				valid_q[chk_idx_s1] <= 1'b0;
				cnt_q               <= cnt_q - CNT_W'(1);
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						rd_idx_q    <= '0;
						match_hit_q <= 1'b0;
						free_hit_q  <= 1'b0;
						state_q     <= scan_op ? ST_SCAN : ST_DONE;
					end
				end
				ST_SCAN: begin
					rd_idx_q <= rd_idx_q + IDX_W'(1);
					if (rd_idx_q == LAST_IDX) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (done_fire) begin
						cnt_q <= cnt_done;
						if (add_new) begin
							valid_q[free_idx_q] <= 1'b1;
						end
						if (op_q == nta_pkg::OP_CLEAR) begin
							valid_q <= '0;
						end
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign out_valid      = out_valid_q;
	assign found          = found_q;
	assign remaining_ttl  = ttl_q;
	assign rejected_full  = full_q;
	assign entries_in_use = use_q;

	`NTA_ASSERT(a_cnt_bound, cnt_q <= CNT_W'(TABLE_DEPTH), "entry count above table depth")
	`NTA_ASSERT(a_cnt_match,
		(state_q == ST_IDLE) |-> ($countones(valid_q) == int'(cnt_q)),
		"entry count out of step with valid marks")
	`NTA_ASSERT(a_chk_in_sweep,
		chk_vld_s1 |-> (state_q == ST_SCAN || state_q == ST_DRAIN),
		"read stage active outside sweep")
	`NTA_ASSERT(a_full_clean,
		(out_valid_q && full_q) |-> (!found_q && ttl_q == '0),
		"full flag with a match or nonzero TTL")
	`NTA_ASSERT_ALWAYS(a_reset_idle,
		!arst_n |-> ##1 (state_q == ST_IDLE && !out_valid_q),
		"sequencer busy in reset")
endmodule
`default_nettype wire
